// ===== rtl/sfl_pkg.sv =====
// Shared types and constants for the serial flash loader command engine.
// No dependencies.
package sfl_pkg;

  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  localparam logic DEST_SERIAL = 1'b0;
  localparam logic DEST_FLASH  = 1'b1;

  localparam logic [2:0] OP_WREN   = 3'd0;
  localparam logic [2:0] OP_ERASE  = 3'd1;
  localparam logic [2:0] OP_PSTART = 3'd2;
  localparam logic [2:0] OP_PDATA  = 3'd3;
  localparam logic [2:0] OP_PEND   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_BLANK  = 3'd6;
  localparam logic [2:0] OP_START  = 3'd7;

  localparam logic [7:0] BYTE_ACK        = 8'h55;
  localparam logic [7:0] BYTE_ERROR      = 8'hfe;
  localparam logic [7:0] BYTE_BLANK_FAIL = 8'hff;

  localparam logic [7:0] CMD_ERASE = 8'h10;
  localparam logic [7:0] CMD_LOAD  = 8'h11;
  localparam logic [7:0] CMD_START = 8'h12;
  localparam logic [7:0] CMD_BLANK = 8'h13;
  localparam logic [7:0] CMD_READ  = 8'h14;

  // Result slots of a job, in emission order
  localparam int SLOT_COUNT = 7;
  localparam logic [2:0] SLOT_PRE    = 3'd0;
  localparam logic [2:0] SLOT_WREN   = 3'd1;
  localparam logic [2:0] SLOT_PSTART = 3'd2;
  localparam logic [2:0] SLOT_PDATA  = 3'd3;
  localparam logic [2:0] SLOT_PEND   = 3'd4;
  localparam logic [2:0] SLOT_MISC   = 3'd5;
  localparam logic [2:0] SLOT_POST   = 3'd6;

  typedef struct packed {
    logic [SLOT_COUNT-1:0] mask;
    logic [7:0]            pre_byte;
    logic [7:0]            post_byte;
    logic [2:0]            misc_op;
    logic [15:0]           address;
    logic [7:0]            data;
  } sfl_job_t;

endpackage

// ===== rtl/sfl_front.sv =====
// Command parser: accepts items, tracks loader state, builds result jobs.
// Depends on sfl_pkg.
module sfl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              kind,
  input  logic [7:0]        byte_value,
  input  logic              rx_error,
  input  logic              reply_blank,
  input  logic              queue_full,
  output logic              item_stall,
  output logic              push,
  output sfl_pkg::sfl_job_t job
);
  import sfl_pkg::*;

  localparam logic [3:0] PH_CMD    = 4'd0;
  localparam logic [3:0] PH_LSIZE  = 4'd1;
  localparam logic [3:0] PH_LLO    = 4'd2;
  localparam logic [3:0] PH_LHI    = 4'd3;
  localparam logic [3:0] PH_LDATA  = 4'd4;
  localparam logic [3:0] PH_RLO    = 4'd5;
  localparam logic [3:0] PH_RHI    = 4'd6;
  localparam logic [3:0] PH_WERASE = 4'd7;
  localparam logic [3:0] PH_WBLANK = 4'd8;
  localparam logic [3:0] PH_WREAD  = 4'd9;

  logic [3:0]  phase, phase_next;
  logic [7:0]  load_size, load_size_next;
  logic [15:0] load_address, load_address_next;
  logic [7:0]  bytes_taken, bytes_taken_next;
  logic        finished, finished_next;
  logic        accept;
  logic [15:0] full_address;
  logic [7:0]  taken_inc;

  assign item_stall   = queue_full;
  assign accept       = item_valid && !queue_full;
  assign full_address = {byte_value, load_address[7:0]};
  assign taken_inc    = bytes_taken + 8'd1;

  always_comb begin
    phase_next        = phase;
    load_size_next    = load_size;
    load_address_next = load_address;
    bytes_taken_next  = bytes_taken;
    finished_next     = finished;
    job               = '0;
    if (accept && !finished) begin
      if (kind == KIND_SERIAL) begin
        if (!rx_error) begin
          unique case (phase) inside
            PH_CMD: begin
              unique case (byte_value)
                CMD_ERASE: begin
                  job.mask[SLOT_WREN] = 1'b1;
                  job.mask[SLOT_MISC] = 1'b1;
                  job.misc_op         = OP_ERASE;
                  phase_next          = PH_WERASE;
                end
                CMD_LOAD: phase_next = PH_LSIZE;
                CMD_START: begin
                  job.mask[SLOT_PRE]  = 1'b1;
                  job.pre_byte        = BYTE_ACK;
                  job.mask[SLOT_MISC] = 1'b1;
                  job.misc_op         = OP_START;
                  finished_next       = 1'b1;
                end
                CMD_BLANK: begin
                  job.mask[SLOT_MISC] = 1'b1;
                  job.misc_op         = OP_BLANK;
                  phase_next          = PH_WBLANK;
                end
                CMD_READ: phase_next = PH_RLO;
                default: begin
                  job.mask[SLOT_PRE]  = 1'b1;
                  job.pre_byte        = BYTE_ERROR;
                  job.mask[SLOT_POST] = 1'b1;
                  job.post_byte       = byte_value;
                end
              endcase
            end
            PH_LSIZE: begin
              load_size_next = byte_value;
              phase_next     = PH_LLO;
            end
            PH_LLO, PH_RLO: begin
              load_address_next = {8'd0, byte_value};
              phase_next        = (phase == PH_LLO) ? PH_LHI : PH_RHI;
            end
            PH_LHI: begin
              load_address_next  = full_address;
              bytes_taken_next   = 8'd0;
              job.mask[SLOT_PRE] = 1'b1;
              job.pre_byte       = BYTE_ACK;
              if (load_size == 8'd0) begin
                job.mask[SLOT_WREN]   = 1'b1;
                job.mask[SLOT_PSTART] = 1'b1;
                job.address           = full_address;
                job.mask[SLOT_PEND]   = 1'b1;
                job.mask[SLOT_POST]   = 1'b1;
                job.post_byte         = BYTE_ACK;
                phase_next            = PH_CMD;
              end else begin
                phase_next = PH_LDATA;
              end
            end
            PH_LDATA: begin
              if (bytes_taken == 8'd0) begin
                job.mask[SLOT_WREN]   = 1'b1;
                job.mask[SLOT_PSTART] = 1'b1;
                job.address           = load_address;
              end
              job.mask[SLOT_PDATA] = 1'b1;
              job.data             = byte_value;
              bytes_taken_next     = taken_inc;
              if (taken_inc >= load_size) begin
                job.mask[SLOT_PEND] = 1'b1;
                job.mask[SLOT_POST] = 1'b1;
                job.post_byte       = BYTE_ACK;
                phase_next          = PH_CMD;
              end
            end
            PH_RHI: begin
              load_address_next   = full_address;
              job.mask[SLOT_PRE]  = 1'b1;
              job.pre_byte        = BYTE_ACK;
              job.mask[SLOT_MISC] = 1'b1;
              job.misc_op         = OP_READ;
              job.address         = full_address;
              phase_next          = PH_WREAD;
            end
            default: ;
          endcase
        end
      end else begin
        unique case (phase)
          PH_WERASE: begin
            job.mask[SLOT_PRE] = 1'b1;
            job.pre_byte       = BYTE_ACK;
            phase_next         = PH_CMD;
          end
          PH_WBLANK: begin
            job.mask[SLOT_PRE] = 1'b1;
            job.pre_byte       = reply_blank ? BYTE_ACK : BYTE_BLANK_FAIL;
            phase_next         = PH_CMD;
          end
          PH_WREAD: begin
            job.mask[SLOT_PRE] = 1'b1;
            job.pre_byte       = byte_value;
            phase_next         = PH_CMD;
          end
          default: ;
        endcase
      end
    end
  end

  assign push = accept && (job.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CMD;
      load_size    <= 8'd0;
      load_address <= 16'd0;
      bytes_taken  <= 8'd0;
      finished     <= 1'b0;
    end else begin
      phase        <= phase_next;
      load_size    <= load_size_next;
      load_address <= load_address_next;
      bytes_taken  <= bytes_taken_next;
      finished     <= finished_next;
    end
  end

endmodule

// ===== rtl/sfl_queue.sv =====
// Short job queue between parser and result sequencer.
// Depends on sfl_pkg.
module sfl_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfl_pkg::sfl_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output sfl_pkg::sfl_job_t head
);
  import sfl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfl_job_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/sfl_back.sv =====
// Result sequencer: walks the slots of the head job, one result per cycle while
// the output is not stalled, into the output register. Depends on sfl_pkg.
module sfl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  sfl_pkg::sfl_job_t head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              dest,
  output logic [2:0]        flash_op,
  output logic [15:0]       flash_address,
  output logic [7:0]        data_byte,
  output logic              last
);
  import sfl_pkg::*;

  logic [SLOT_COUNT-1:0] done;
  logic [SLOT_COUNT-1:0] remaining;
  logic [SLOT_COUNT-1:0] sel;
  logic [2:0]            idx;
  logic                  is_last;
  logic                  load;
  logic                  r_dest;
  logic [2:0]            r_op;
  logic [15:0]           r_addr;
  logic [7:0]            r_data;

  assign remaining = head.mask & ~done;

  always_comb begin
    idx = SLOT_PRE;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (remaining[i]) idx = 3'(i);
    end
  end

  assign sel     = SLOT_COUNT'(1) << idx;
  assign is_last = ((remaining & ~sel) == '0);
  assign load    = head_valid && (!result_valid || !result_stall);
  assign pop     = load && is_last;

  always_comb begin
    r_dest = DEST_FLASH;
    r_op   = OP_WREN;
    r_addr = 16'd0;
    r_data = 8'd0;
    unique case (idx)
      SLOT_PRE: begin
        r_dest = DEST_SERIAL;
        r_data = head.pre_byte;
      end
      SLOT_WREN:   r_op = OP_WREN;
      SLOT_PSTART: begin
        r_op   = OP_PSTART;
        r_addr = head.address;
      end
      SLOT_PDATA: begin
        r_op   = OP_PDATA;
        r_data = head.data;
      end
      SLOT_PEND: r_op = OP_PEND;
      SLOT_MISC: begin
        r_op   = head.misc_op;
        r_addr = (head.misc_op == OP_READ) ? head.address : 16'd0;
      end
      SLOT_POST: begin
        r_dest = DEST_SERIAL;
        r_data = head.post_byte;
      end
      default: r_dest = DEST_SERIAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        done         <= is_last ? '0 : (done | sel);
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest          <= r_dest;
      flash_op      <= r_op;
      flash_address <= r_addr;
      data_byte     <= r_data;
      last          <= is_last;
    end
  end

endmodule

// ===== rtl/serial_flash_loader_command_engine.sv =====
// Top level of the serial flash loader command engine: parser, job queue
// and result sequencer. Depends on sfl_pkg, sfl_front, sfl_queue, sfl_back.
//
//   channel  handshake                    payload
//   item     item_valid / item_stall      kind, byte_value, rx_error, reply_blank
//   result   result_valid / result_stall  dest, flash_op, flash_address,
//                                         data_byte, last
//
// An item is taken every cycle while the job queue has room; it leaves at most
// one job. The sequencer emits one result per cycle while results are not stalled;
// a job holds 1 to 5 results. Jobs are queued; each result is then registered at the output.
// Reset clears parser state, the queue and the output register's valid.
// A stalled result holds the sequencer; the queue then fills and stalls items.
module serial_flash_loader_command_engine #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [7:0]  byte_value,
  input  logic        rx_error,
  input  logic        reply_blank,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        dest,
  output logic [2:0]  flash_op,
  output logic [15:0] flash_address,
  output logic [7:0]  data_byte,
  output logic        last
);
  import sfl_pkg::*;

  sfl_job_t front_job;
  sfl_job_t head_job;
  logic     push;
  logic     pop;
  logic     queue_full;
  logic     head_valid;

  sfl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .kind        (kind),
    .byte_value  (byte_value),
    .rx_error    (rx_error),
    .reply_blank (reply_blank),
    .queue_full  (queue_full),
    .item_stall  (item_stall),
    .push        (push),
    .job         (front_job)
  );

  sfl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (front_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head_job)
  );

  sfl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head_job),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .dest          (dest),
    .flash_op      (flash_op),
    .flash_address (flash_address),
    .data_byte     (data_byte),
    .last          (last)
  );

endmodule

// ===== tb/tb_serial_flash_loader_command_engine.sv =====
// Self-checking testbench for serial_flash_loader_command_engine: a directed table
// then random command streams, each item checked against an in-bench loader model.
// Depends on sfl_pkg and the engine RTL only.
module tb_serial_flash_loader_command_engine;
  import sfl_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_CAP   = 40;
  localparam int PHASE_ITEMS = 90;

  typedef enum logic [3:0] {
    P_CMD, P_SIZE, P_ADDR_LO, P_ADDR_HI, P_DATA, P_RD_LO, P_RD_HI,
    P_WAIT_ERASE, P_WAIT_BLANK, P_WAIT_READ
  } cmd_phase_t;

  typedef struct packed {
    logic        dest;
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        last;
  } loader_result_t;

  // typed = 1: n serial bytes t0, t1 are the whole answer
  typedef struct packed {
    logic       k;
    logic [7:0] b;
    logic       err;
    logic       blank;
    logic       typed;
    logic [1:0] n;
    logic [7:0] t0;
    logic [7:0] t1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        kind;
  logic [7:0]  byte_value;
  logic        rx_error;
  logic        reply_blank;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        dest;
  logic [2:0]  flash_op;
  logic [15:0] flash_address;
  logic [7:0]  data_byte;
  logic        last;

  cmd_phase_t  cmd_phase;
  logic [7:0]  blk_size;
  logic [15:0] blk_addr;
  logic [7:0]  blk_count;
  logic        target_started;

  loader_result_t item_results[$];
  loader_result_t owed_results[$];

  logic       row_typed;
  logic [1:0] row_count;
  logic [7:0] row_bytes [2];

  int fail_count   = 0;
  int results_seen = 0;
  int cycle_no     = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int phase_no      = 0;
  bit big_load_done = 1'b0;

  dir_row_t dir_rows [28] = '{
    '{KIND_REPLY,  8'hff,     1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, CMD_ERASE, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'h00,     1'b0, 1'b0, 1'b1, 2'd2, BYTE_ERROR, 8'h00},
    '{KIND_SERIAL, 8'hff,     1'b0, 1'b0, 1'b1, 2'd2, BYTE_ERROR, 8'hff},
    '{KIND_SERIAL, CMD_ERASE, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, CMD_READ,  1'b0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{KIND_REPLY,  8'h00,     1'b0, 1'b0, 1'b1, 2'd1, BYTE_ACK, 8'h00},
    '{KIND_SERIAL, CMD_BLANK, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_REPLY,  8'h00,     1'b0, 1'b0, 1'b1, 2'd1, BYTE_BLANK_FAIL, 8'h00},
    '{KIND_SERIAL, CMD_BLANK, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_REPLY,  8'h00,     1'b0, 1'b1, 1'b1, 2'd1, BYTE_ACK, 8'h00},
    '{KIND_SERIAL, CMD_READ,  1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'hff,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'hff,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_REPLY,  8'h00,     1'b0, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00},
    '{KIND_SERIAL, CMD_LOAD,  1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'h00,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'hff,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'hff,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, CMD_LOAD,  1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'h01,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'h00,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'h00,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, CMD_START, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, 8'ha5,     1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    // closing rows: start target, then everything is ignored
    '{KIND_SERIAL, CMD_START, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_SERIAL, CMD_ERASE, 1'b0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{KIND_REPLY,  8'h3c,     1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00}
  };

  int send_pcts  [4] = '{0, 72, 0, 18};
  int stall_pcts [4] = '{0, 0, 72, 18};

  serial_flash_loader_command_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .byte_value    (byte_value),
    .rx_error      (rx_error),
    .reply_blank   (reply_blank),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .dest          (dest),
    .flash_op      (flash_op),
    .flash_address (flash_address),
    .data_byte     (data_byte),
    .last          (last)
  );

  always #1 clk = ~clk;

  task automatic emit(input logic d, input logic [2:0] op, input logic [15:0] a,
                      input logic [7:0] v);
    loader_result_t r;
    r = '{d, op, a, v, 1'b0};
    item_results.push_back(r);
  endtask

  task automatic decode_serial_byte(input logic [7:0] b);
    case (cmd_phase) inside
      P_CMD: begin
        case (b)
          CMD_ERASE: begin
            emit(DEST_FLASH, OP_WREN, '0, '0);
            emit(DEST_FLASH, OP_ERASE, '0, '0);
            cmd_phase = P_WAIT_ERASE;
          end
          CMD_LOAD: cmd_phase = P_SIZE;
          CMD_START: begin
            emit(DEST_SERIAL, '0, '0, BYTE_ACK);
            emit(DEST_FLASH, OP_START, '0, '0);
            target_started = 1'b1;
          end
          CMD_BLANK: begin
            emit(DEST_FLASH, OP_BLANK, '0, '0);
            cmd_phase = P_WAIT_BLANK;
          end
          CMD_READ: cmd_phase = P_RD_LO;
          default: begin
            emit(DEST_SERIAL, '0, '0, BYTE_ERROR);
            emit(DEST_SERIAL, '0, '0, b);
          end
        endcase
      end
      P_SIZE: begin
        blk_size  = b;
        cmd_phase = P_ADDR_LO;
      end
      P_ADDR_LO, P_RD_LO: begin
        blk_addr  = {8'h00, b};
        cmd_phase = (cmd_phase == P_ADDR_LO) ? P_ADDR_HI : P_RD_HI;
      end
      P_ADDR_HI: begin
        blk_addr[15:8] = b;
        blk_count      = '0;
        emit(DEST_SERIAL, '0, '0, BYTE_ACK);
        if (blk_size == 8'h00) begin
          emit(DEST_FLASH, OP_WREN, '0, '0);
          emit(DEST_FLASH, OP_PSTART, blk_addr, '0);
          emit(DEST_FLASH, OP_PEND, '0, '0);
          emit(DEST_SERIAL, '0, '0, BYTE_ACK);
          cmd_phase = P_CMD;
        end else begin
          cmd_phase = P_DATA;
        end
      end
      P_DATA: begin
        if (blk_count == 8'h00) begin
          emit(DEST_FLASH, OP_WREN, '0, '0);
          emit(DEST_FLASH, OP_PSTART, blk_addr, '0);
        end
        emit(DEST_FLASH, OP_PDATA, '0, b);
        blk_count = blk_count + 8'd1;
        if (blk_count >= blk_size) begin
          emit(DEST_FLASH, OP_PEND, '0, '0);
          emit(DEST_SERIAL, '0, '0, BYTE_ACK);
          cmd_phase = P_CMD;
        end
      end
      P_RD_HI: begin
        blk_addr[15:8] = b;
        emit(DEST_SERIAL, '0, '0, BYTE_ACK);
        emit(DEST_FLASH, OP_READ, blk_addr, '0);
        cmd_phase = P_WAIT_READ;
      end
      default: ;
    endcase
  endtask

  task automatic decode_loader_item(input logic k, input logic [7:0] b, input logic e,
                                    input logic bl);
    item_results.delete();
    if (!target_started) begin
      if (k == KIND_SERIAL) begin
        if (!e) decode_serial_byte(b);
      end else begin
        case (cmd_phase)
          P_WAIT_ERASE: begin
            emit(DEST_SERIAL, '0, '0, BYTE_ACK);
            cmd_phase = P_CMD;
          end
          P_WAIT_BLANK: begin
            emit(DEST_SERIAL, '0, '0, bl ? BYTE_ACK : BYTE_BLANK_FAIL);
            cmd_phase = P_CMD;
          end
          P_WAIT_READ: begin
            emit(DEST_SERIAL, '0, '0, b);
            cmd_phase = P_CMD;
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("MISMATCH at result %0d: %s", results_seen, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    loader_result_t got;
    loader_result_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        decode_loader_item(kind, byte_value, rx_error, reply_blank);
        if (row_typed) begin
          item_results.delete();
          for (int i = 0; i < int'(row_count); i++) emit(DEST_SERIAL, '0, '0, row_bytes[i]);
        end
        if (item_results.size() > 0) item_results[$].last = 1'b1;
        foreach (item_results[i]) owed_results.push_back(item_results[i]);
      end
      if (result_valid && !result_stall) begin
        got = '{dest, flash_op, flash_address, data_byte, last};
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = owed_results.pop_front();
          if (got.dest !== want.dest)
            report_mismatch($sformatf("dest %0d, want %0d", got.dest, want.dest));
          if (got.op !== want.op)
            report_mismatch($sformatf("flash_op %0d, want %0d", got.op, want.op));
          if (got.addr !== want.addr)
            report_mismatch($sformatf("flash_address %h, want %h", got.addr, want.addr));
          if (got.data !== want.data)
            report_mismatch($sformatf("data_byte %h, want %h", got.data, want.data));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) result_stall <= ($urandom_range(0, 99) < stall_pct);

  task automatic send_item(input logic k, input logic [7:0] b, input logic e, input logic bl);
    item_valid  <= 1'b1;
    kind        <= k;
    byte_value  <= b;
    rx_error    <= e;
    reply_blank <= bl;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic hold_until_drained();
    item_valid <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_rows(input int first, input int final_row);
    for (int i = first; i <= final_row; i++) begin
      row_typed    = dir_rows[i].typed;
      row_count    = dir_rows[i].n;
      row_bytes[0] = dir_rows[i].t0;
      row_bytes[1] = dir_rows[i].t1;
      send_item(dir_rows[i].k, dir_rows[i].b, dir_rows[i].err, dir_rows[i].blank);
    end
    row_typed = 1'b0;
  endtask

  // mostly well-formed commands with random content; some noise
  task automatic pick_item(output logic k, output logic [7:0] b, output logic e,
                           output logic bl, output bit counts);
    bit waiting;
    int r;
    waiting = cmd_phase inside {P_WAIT_ERASE, P_WAIT_BLANK, P_WAIT_READ};
    k  = KIND_SERIAL;
    b  = 8'($urandom_range(0, 255));
    e  = 1'b0;
    bl = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 10) begin
      if ($urandom_range(0, 1) == 0) e = 1'b1;
      else k = KIND_REPLY;
    end else if (waiting) begin
      if ($urandom_range(0, 99) >= 15) k = KIND_REPLY;
    end else if (cmd_phase == P_CMD) begin
      r = $urandom_range(0, 99);
      if (r < 15)      b = CMD_ERASE;
      else if (r < 45) b = CMD_LOAD;
      else if (r < 60) b = CMD_BLANK;
      else if (r < 80) b = CMD_READ;
      else
        while (b inside {CMD_ERASE, CMD_LOAD, CMD_START, CMD_BLANK, CMD_READ})
          b = 8'($urandom_range(0, 255));
    end else if (cmd_phase == P_SIZE) begin
      if (phase_no == 1 && !big_load_done) begin
        b = 8'hff;
        big_load_done = 1'b1;
      end else if ($urandom_range(0, 99) < 5) begin
        b = 8'($urandom_range(9, 40));
      end else begin
        b = 8'($urandom_range(0, 8));
      end
    end
    counts = (k == KIND_REPLY) ? waiting : (!e && !waiting);
  endtask

  initial begin
    logic       k;
    logic [7:0] b;
    logic       e;
    logic       bl;
    bit         counts;
    int         taken;
    rst            = 1'b1;
    item_valid     = 1'b0;
    kind           = KIND_SERIAL;
    byte_value     = 8'h00;
    rx_error       = 1'b0;
    reply_blank    = 1'b0;
    row_typed      = 1'b0;
    row_count      = 2'd0;
    cmd_phase      = P_CMD;
    blk_size       = '0;
    blk_addr       = '0;
    blk_count      = '0;
    target_started = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    run_rows(0, 24);

    for (int p = 0; p < 4; p++) begin
      hold_until_drained();
      phase_no      = p;
      send_idle_pct = send_pcts[p];
      stall_pct     = stall_pcts[p];
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        pick_item(k, b, e, bl, counts);
        if (counts) taken++;
        send_item(k, b, e, bl);
        if ($urandom_range(0, 59) == 0) hold_until_drained();
      end
    end

    // finish any open command before starting the target
    while (cmd_phase != P_CMD) begin
      pick_item(k, b, e, bl, counts);
      send_item(k, b, e, bl);
    end
    send_idle_pct = 0;
    run_rows(25, 27);

    hold_until_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sfl_pkg.sv
rtl/sfl_front.sv
rtl/sfl_queue.sv
rtl/sfl_back.sv
rtl/serial_flash_loader_command_engine.sv
tb/tb_serial_flash_loader_command_engine.sv
